>>> rtl/sia_pkg.sv
`timescale 1ns / 1ps
package sia_pkg;
  localparam int WORD_BITS = 32;
  localparam int STACK_DEPTH = 64;
  localparam int PTR_BITS = $clog2(STACK_DEPTH);
  localparam int CNT_BITS = $clog2(STACK_DEPTH + 1);
  localparam int STEP_BITS = $clog2(WORD_BITS + 1);

  typedef logic [WORD_BITS-1:0] word_t;

  typedef enum logic [3:0] {
    ACT_PUSH = 4'd0, ACT_ADD = 4'd1, ACT_SUB = 4'd2, ACT_MUL = 4'd3,
    ACT_DIV = 4'd4, ACT_MOD = 4'd5, ACT_POW = 4'd6, ACT_AND = 4'd7,
    ACT_OR = 4'd8, ACT_XOR = 4'd9, ACT_NOT = 4'd10, ACT_INC = 4'd11,
    ACT_DEC = 4'd12
  } action_t;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_UNDER = 2'd1;
  localparam logic [1:0] ST_OVER = 2'd2;
  localparam logic [1:0] ST_DIVZ = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_DECIDE, S_ITER, S_WRITE, S_OUT
  } state_t;

  typedef struct packed {
    logic start;
    logic is_div;
  } iter_ctl_t;
endpackage

>>> rtl/sia_iter.sv
`timescale 1ns / 1ps
module sia_iter
  import sia_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  iter_ctl_t ctl,
  input  word_t     a,
  input  word_t     b,
  output logic      done,
  output word_t     quo,
  output word_t     rem,
  output word_t     pw
);
  logic [STEP_BITS-1:0] step;
  logic busy, is_div, neg_q, neg_r;
  word_t dvd, dvs, r, q, base, e, acc;
  logic [WORD_BITS:0] trial;
  logic [2*WORD_BITS-1:0] m_acc, m_base;

  assign trial = {1'b0, r[WORD_BITS-2:0], dvd[WORD_BITS-1]} - {1'b0, dvs};
  assign m_acc = acc * base;
  assign m_base = base * base;

  // run one radix-2 divide step or one square-and-multiply step per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= !ctl.start && busy && (step == STEP_BITS'(1));
      if (ctl.start) begin
        busy <= 1'b1;
        is_div <= ctl.is_div;
        step <= STEP_BITS'(WORD_BITS);
        dvd <= a[WORD_BITS-1] ? -a : a;
        dvs <= b[WORD_BITS-1] ? -b : b;
        neg_q <= a[WORD_BITS-1] ^ b[WORD_BITS-1];
        neg_r <= a[WORD_BITS-1];
        r <= '0;
        q <= '0;
        base <= a;
        e <= b[WORD_BITS-1] ? word_t'(0) : b;
        acc <= word_t'(1);
      end else if (busy) begin
        if (is_div) begin
          if (!trial[WORD_BITS]) r <= trial[WORD_BITS-1:0];
          else r <= {r[WORD_BITS-2:0], dvd[WORD_BITS-1]};
          q <= {q[WORD_BITS-2:0], ~trial[WORD_BITS]};
          dvd <= {dvd[WORD_BITS-2:0], 1'b0};
        end else begin
          if (e[0]) acc <= m_acc[WORD_BITS-1:0];
          base <= m_base[WORD_BITS-1:0];
          e <= e >> 1;
        end
        step <= step - STEP_BITS'(1);
        if (step == STEP_BITS'(1)) busy <= 1'b0;
      end
    end
  end

  assign quo = neg_q ? -q : q;
  assign rem = neg_r ? -r : r;
  assign pw = acc;
endmodule

>>> rtl/stack_integer_alu.sv
`timescale 1ns / 1ps
// RPN stack calculator on 32-bit words, 64 entries in a synchronous RAM with
// one read and one write per cycle. One action per input word, one result word
// per action (top, depth, status), handed over through an output register.
// Each action passes through the read, decide and iterate states. A push or an
// action that only reports a status then goes to the output state; every other
// action passes through the write state first, div, mod and pow only after
// waiting in the iterate state for a shared iterative unit of 32 steps (radix-2
// divide or square-and-multiply). The next word can be accepted in the cycle
// after the result is loaded; a result still waiting in the output register
// holds the following action in its last state.
module stack_integer_alu
  import sia_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,  // action[3:0], literal[35:4], zero pad
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata   // top_value[31:0], depth_now[38:32], status[40:39]
);
  word_t mem [STACK_DEPTH];
  state_t state, state_next;
  logic [3:0] act;
  word_t lit, a, b, rd, res, top;
  logic [CNT_BITS-1:0] sp;
  logic [1:0] stat;
  logic rd_second, wr_en;
  logic [PTR_BITS-1:0] rd_addr, wr_addr;
  iter_ctl_t ictl;
  logic idone;
  word_t quo, rem, pw;
  logic [2*WORD_BITS-1:0] mprod;
  logic [CNT_BITS-1:0] need;
  logic unary, binary;

  assign unary = (act == ACT_NOT) || (act == ACT_INC) || (act == ACT_DEC);
  assign binary = (act >= ACT_ADD) && (act <= ACT_XOR);
  assign need = binary ? CNT_BITS'(2) : unary ? CNT_BITS'(1) : CNT_BITS'(0);
  assign mprod = a * b;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (s_tvalid) state_next = S_READ;
      S_READ: state_next = S_DECIDE;
      S_DECIDE: state_next = S_ITER;
      S_ITER: begin
        if (act == ACT_PUSH || act > ACT_DEC || sp < need) state_next = S_OUT;
        else if (binary && (act == ACT_DIV || act == ACT_MOD) && b == '0)
          state_next = S_OUT;
        else if (act == ACT_DIV || act == ACT_MOD || act == ACT_POW) begin
          if (idone) state_next = S_WRITE;
        end else state_next = S_WRITE;
      end
      S_WRITE: state_next = S_OUT;
      S_OUT: if (!m_tvalid || m_tready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // outputs and control
  always_comb begin
    s_tready = (state == S_IDLE);
    ictl.start = (state == S_DECIDE) && sp >= need && binary &&
                 (act == ACT_POW || ((act == ACT_DIV || act == ACT_MOD) && b != '0));
    ictl.is_div = (act != ACT_POW);
    rd_second = (state == S_READ);
    wr_en = (state == S_WRITE) ||
            (state == S_ITER && act == ACT_PUSH && sp != CNT_BITS'(STACK_DEPTH));
  end

  always_comb begin
    case (act)
      ACT_PUSH: res = lit;
      ACT_ADD: res = a + b;
      ACT_SUB: res = a - b;
      ACT_MUL: res = mprod[WORD_BITS-1:0];
      ACT_DIV: res = quo;
      ACT_MOD: res = rem;
      ACT_POW: res = pw;
      ACT_AND: res = a & b;
      ACT_OR: res = a | b;
      ACT_XOR: res = a ^ b;
      ACT_NOT: res = ~b;
      ACT_INC: res = b + word_t'(1);
      ACT_DEC: res = b - word_t'(1);
      default: res = b;
    endcase
  end

  // top address in idle, second address in read
  assign rd_addr = rd_second ? PTR_BITS'(sp - CNT_BITS'(2)) : PTR_BITS'(sp - CNT_BITS'(1));
  assign wr_addr = (act == ACT_PUSH) ? PTR_BITS'(sp) :
                   binary ? PTR_BITS'(sp - CNT_BITS'(2)) : PTR_BITS'(sp - CNT_BITS'(1));

  // stack memory, push writes the literal on leaving the iterate state
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= res;
    rd <= mem[rd_addr];
  end

  // second entry comes straight from the memory in the decide state
  sia_iter u_iter (.clk, .rst, .ctl(ictl), .a(rd), .b, .done(idone), .quo, .rem, .pw);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      sp <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_IDLE && s_tvalid) begin
        act <= s_tdata[3:0];
        lit <= s_tdata[35:4];
      end
      if (state == S_READ) b <= rd;
      if (state == S_DECIDE) a <= rd;
      // settle push and status-only actions
      if (state == S_ITER && state_next == S_OUT) begin
        if (act == ACT_PUSH && sp != CNT_BITS'(STACK_DEPTH)) begin
          sp <= sp + CNT_BITS'(1);
          top <= lit;
          stat <= ST_OK;
        end else begin
          top <= (sp == '0) ? '0 : b;
          if (act == ACT_PUSH) stat <= ST_OVER;
          else if (act > ACT_DEC) stat <= ST_OK;
          else if (sp < need) stat <= ST_UNDER;
          else stat <= ST_DIVZ;
        end
      end
      if (state == S_WRITE) begin
        stat <= ST_OK;
        top <= res;
        if (binary) sp <= sp - CNT_BITS'(1);
      end
      // load the output register once it is free
      if (state == S_OUT && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
        m_tdata <= {7'd0, stat, sp, top};
      end else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  a_depth: assert property (@(posedge clk) disable iff (rst)
    sp <= CNT_BITS'(STACK_DEPTH)) else $error("depth beyond stack");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata))) else $error("result changed");
  a_room: assert property (@(posedge clk) disable iff (rst)
    (state == S_WRITE) |-> (sp >= need)) else $error("write without operands");
endmodule
